[design/wdad_pkg.sv]
// Shared types and constants for the window deviation anomaly detector.
// Used by every module of the block; depends on nothing else.
package wdad_pkg;

  localparam int CNT_BITS     = 16;
  localparam int THR_BITS     = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWEEP_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUIET_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_EVENTS     = 3'd4;

  // register values after reset
  localparam logic [THR_BITS-1:0] LOW_THRESHOLD_RST  = 24'd30000;
  localparam logic [THR_BITS-1:0] HIGH_THRESHOLD_RST = 24'd150000;
  localparam logic [CNT_BITS-1:0] QUIET_LIMIT_RST    = 16'd250;
  localparam logic [CNT_BITS-1:0] MIN_EVENTS_RST     = 16'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SMALL = 2'd1,
    EV_LARGE = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_ROT,
    ST_DEV,
    ST_DEV_WAIT,
    ST_OUT
  } wdad_state_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

endpackage

[design/wdad_cell.sv]
// One window cell: holds a single sample and takes its neighbour's on a shift.
// Depends on wdad_pkg only by house convention (no items used beyond the import).
module wdad_cell import wdad_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] d,
  output logic [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[design/wdad_cdiv.sv]
// Unsigned divide by a constant: reciprocal multiply plus one correction step.
// The product, then the estimate are registered behind start, and done marks the result; depends on wdad_pkg.
module wdad_cdiv import wdad_pkg::*; #(
  parameter int DIVISOR = 10,
  parameter int XBITS   = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [XBITS-1:0] x,
  output logic             done,
  output logic [XBITS-1:0] q
);

  localparam longint unsigned RECIP_L = (64'd1 << XBITS) / DIVISOR;
  localparam logic [XBITS-1:0] RECIP  = XBITS'(RECIP_L);
  localparam logic [XBITS-1:0] DIV_C  = XBITS'(DIVISOR);

  logic               v1, v2;
  logic [XBITS-1:0]   x1, x2;
  logic [2*XBITS-1:0] prod;
  logic [XBITS-1:0]   qe;
  logic [XBITS-1:0]   qn;
  logic [XBITS-1:0]   rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  // estimate is exact or one low, since x < 2**XBITS
  always_ff @(posedge clk) begin
    x1   <= x;
    prod <= {{XBITS{1'b0}}, x} * {{XBITS{1'b0}}, RECIP};
    x2   <= x1;
    qe   <= prod[2*XBITS-1:XBITS];
  end

  always_comb begin
    qn   = qe * DIV_C;
    rem  = x2 - qn;
    q    = (rem >= DIV_C) ? qe + 1'b1 : qe;
    done = v2;
  end

endmodule

[design/window_deviation_anomaly_detector.sv]
// Top level of the window deviation anomaly detector: window cell row, running
// sum, shared constant divider and event logic. Depends on wdad_pkg, wdad_cell, wdad_cdiv.
//
//  channel  | direction | signals                              | payload
//  ---------+-----------+--------------------------------------+---------------------------
//  s        | in        | s_tvalid s_tready s_tdata            | sample
//  m        | out       | m_tvalid m_tready m_tdata m_tuser    | mean, deviation, kind,
//           |           |                                      | group flag/count; analysed
//  cfg      | in        | cfg_we cfg_index cfg_data            | register writes
//
// A sample that completes the window is processed in order: the running sum is updated
// at the transfer edge, then come the mean divide, one walk round the cell ring for the
// absolute deviation sum, the deviation divide and the event decision. The next sample
// is taken only once the decision state has loaded its result into the output register,
// so no sample is taken while the one before it is still in the walk or a divide.
// While the window fills, the decision state follows the transfer and loads a result
// into the output register; the next sample is taken once it has done so.
// Reset is synchronous and clears window, counters, latches, configuration registers and the output valid flag.
// A stalled result holds in the output register; the next sample is taken meanwhile
// and its processing holds in the decision state until the output register frees.
module window_deviation_anomaly_detector import wdad_pkg::*; #(
  parameter int WINDOW_LEN  = 10,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  // slave side
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_BITS-1:0] sample
  // master side
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // from bit 0: window_mean, deviation, event_kind, group_done, group_count, zero pad
  output logic [((2*SAMPLE_BITS+19+7)/8)*8-1:0] m_tdata,
  output logic                               m_tuser,   // analysed
  // configuration
  input  logic                               cfg_we,
  input  logic [CFG_IDX_BITS-1:0]            cfg_index,
  input  logic [CFG_DATA_BITS-1:0]           cfg_data
);

  localparam int ACC_BITS   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int FILL_BITS  = $clog2(WINDOW_LEN + 1);
  localparam int ROT_BITS   = $clog2(WINDOW_LEN);
  localparam int OUT_FIELDS = 2*SAMPLE_BITS + 2 + 1 + CNT_BITS;
  localparam int OUT_TDATA  = ((OUT_FIELDS + 7) / 8) * 8;
  localparam int CMP_BITS   = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WINDOW_LEN);
  localparam logic [ROT_BITS-1:0]  ROT_LAST  = ROT_BITS'(WINDOW_LEN - 1);

  // configuration registers
  logic                sweep_enable;
  logic [THR_BITS-1:0] low_threshold;
  logic [THR_BITS-1:0] high_threshold;
  logic [CNT_BITS-1:0] quiet_limit;
  logic [CNT_BITS-1:0] min_events;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_enable   <= 1'b0;
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
      quiet_limit    <= QUIET_LIMIT_RST;
      min_events     <= MIN_EVENTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWEEP_ENABLE:   sweep_enable   <= cfg_data[0];
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data[THR_BITS-1:0];
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data[THR_BITS-1:0];
        CFG_QUIET_LIMIT:    quiet_limit    <= cfg_data[CNT_BITS-1:0];
        CFG_MIN_EVENTS:     min_events     <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  wdad_state_t state, state_next;

  logic                   in_xfer;
  logic                   take;       // transfer while sweeping
  logic [SAMPLE_BITS-1:0] new_sample;

  assign s_tready   = (state == ST_IDLE);
  assign in_xfer    = s_tvalid && s_tready;
  assign take       = in_xfer && sweep_enable;
  assign new_sample = s_tdata[SAMPLE_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Window: a ring of cells. A new sample enters at the top and the oldest drops
  // out of cell 0; during the deviation walk cell 0 wraps round to the top, so
  // after WINDOW_LEN shifts the window is back in order.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] cell_q [WINDOW_LEN];
  logic                   ring_shift;

  assign ring_shift = take || (state == ST_ROT);

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
      logic [SAMPLE_BITS-1:0] cell_d;
      if (gi == WINDOW_LEN - 1) begin : g_top
        assign cell_d = take ? new_sample : cell_q[0];
      end else begin : g_mid
        assign cell_d = cell_q[gi+1];
      end
      wdad_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring_shift),
        .d     (cell_d),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  // running window sum: add the entering sample, drop the leaving one
  logic signed [ACC_BITS:0] win_sum;
  logic        [ACC_BITS:0] neg_sum;
  logic [ACC_BITS-1:0]      abs_sum;
  logic [ACC_BITS:0]        new_ext, old_ext;

  assign new_ext = {{(ACC_BITS+1-SAMPLE_BITS){new_sample[SAMPLE_BITS-1]}}, new_sample};
  assign old_ext = {{(ACC_BITS+1-SAMPLE_BITS){cell_q[0][SAMPLE_BITS-1]}}, cell_q[0]};
  assign neg_sum = -win_sum;
  assign abs_sum = win_sum[ACC_BITS] ? neg_sum[ACC_BITS-1:0] : win_sum[ACC_BITS-1:0];

  logic [FILL_BITS-1:0] fill_count;
  logic                 analysed_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum       <= '0;
      fill_count    <= '0;
      analysed_pend <= 1'b0;
    end else if (take) begin
      win_sum <= win_sum + new_ext - old_ext;
      if (fill_count < FILL_FULL) begin
        fill_count    <= fill_count + 1'b1;
        analysed_pend <= (fill_count + 1'b1 == FILL_FULL);
      end else begin
        analysed_pend <= 1'b1;
      end
    end
  end

  // shared divide by WINDOW_LEN, used once for the mean and once for the deviation
  logic                div_start, div_done;
  logic [ACC_BITS-1:0] div_x, div_q;
  logic [ACC_BITS-1:0] dsum;

  assign div_start = (state == ST_MEAN) || (state == ST_DEV);
  assign div_x     = (state == ST_MEAN) ? abs_sum : dsum;

  wdad_cdiv #(.DIVISOR(WINDOW_LEN), .XBITS(ACC_BITS)) u_cdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .done  (div_done),
    .q     (div_q)
  );

  // mean, truncated toward zero: divide the magnitude, restore the sign
  logic [SAMPLE_BITS-1:0] mean_mag, mean_val;
  logic [SAMPLE_BITS-1:0] win_mean;
  logic [SAMPLE_BITS-1:0] dev;
  logic [ROT_BITS-1:0]    rot_cnt;

  assign mean_mag = div_q[SAMPLE_BITS-1:0];
  assign mean_val = win_sum[ACC_BITS] ? -mean_mag : mean_mag;

  // absolute distance of the sample in cell 0 from the mean
  logic [SAMPLE_BITS:0]   diff, neg_diff;
  logic [SAMPLE_BITS-1:0] abs_diff;

  assign diff     = {cell_q[0][SAMPLE_BITS-1], cell_q[0]} - {win_mean[SAMPLE_BITS-1], win_mean};
  assign neg_diff = -diff;
  assign abs_diff = diff[SAMPLE_BITS] ? neg_diff[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (state == ST_MEAN_WAIT && div_done) begin
      win_mean <= mean_val;
      dsum     <= '0;
    end else if (state == ST_ROT) begin
      dsum <= dsum + {{(ACC_BITS-SAMPLE_BITS){1'b0}}, abs_diff};
    end
    if (state == ST_DEV_WAIT && div_done) begin
      dev <= div_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cnt <= '0;
    end else if (state == ST_ROT) begin
      rot_cnt <= (rot_cnt == ROT_LAST) ? '0 : rot_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Event decision and grouping
  // ---------------------------------------------------------------------------
  logic                small_latched, large_latched;
  logic [CNT_BITS-1:0] quiet_count, event_count, target_count;

  logic                small_next, large_next;
  logic [CNT_BITS-1:0] quiet_next, event_next, target_next;
  event_kind_t         kind_next;
  logic                grouped_next;
  logic [CMP_BITS-1:0] dev_c, low_c, high_c;
  logic                in_small, in_large;
  logic                out_free, out_load;

  assign dev_c    = CMP_BITS'(dev);
  assign low_c    = CMP_BITS'(low_threshold);
  assign high_c   = CMP_BITS'(high_threshold);
  assign in_small = (dev_c > low_c) && (dev_c < high_c);
  assign in_large = (dev_c >= high_c);

  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_OUT) && out_free;

  always_comb begin
    small_next   = small_latched;
    large_next   = large_latched;
    quiet_next   = quiet_count;
    event_next   = event_count;
    target_next  = target_count;
    kind_next    = EV_NONE;
    grouped_next = 1'b0;
    if (in_small) begin
      if (!small_latched) begin
        event_next = sat_inc(event_count);
        small_next = 1'b1;
        quiet_next = '0;
        kind_next  = EV_SMALL;
      end
    end else if (in_large) begin
      if (!large_latched) begin
        event_next = sat_inc(event_count);
        large_next = 1'b1;
        quiet_next = '0;
        kind_next  = EV_LARGE;
      end
    end else begin
      small_next = 1'b0;
      large_next = 1'b0;
      quiet_next = sat_inc(quiet_count);
    end
    // enough quiet after enough events: fold them into one target
    if (quiet_next > quiet_limit && event_next > min_events) begin
      target_next  = sat_inc(target_count);
      quiet_next   = '0;
      event_next   = '0;
      grouped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_latched <= 1'b0;
      large_latched <= 1'b0;
      quiet_count   <= '0;
      event_count   <= '0;
      target_count  <= '0;
    end else if (out_load && analysed_pend) begin
      small_latched <= small_next;
      large_latched <= large_next;
      quiet_count   <= quiet_next;
      event_count   <= event_next;
      target_count  <= target_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [OUT_TDATA-1:0] out_data;
  logic                 out_user;
  logic                 out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_user <= analysed_pend;
      if (analysed_pend) begin
        out_data <= {{(OUT_TDATA-OUT_FIELDS){1'b0}}, target_next, grouped_next,
                     kind_next, dev, win_mean};
      end else begin
        out_data <= {{(OUT_TDATA-OUT_FIELDS){1'b0}}, target_count, 1'b0,
                     EV_NONE, {SAMPLE_BITS{1'b0}}, {SAMPLE_BITS{1'b0}}};
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          // a sample that does not complete the window goes straight out
          state_next = (fill_count >= FILL_FULL - 1'b1) ? ST_MEAN : ST_OUT;
        end
      end
      ST_MEAN:      state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_next = ST_ROT;
      ST_ROT:       if (rot_cnt == ROT_LAST) state_next = ST_DEV;
      ST_DEV:       state_next = ST_DEV_WAIT;
      ST_DEV_WAIT:  if (div_done) state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_FULL)
    else $error("fill count beyond window length");

  a_div_only_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_MEAN_WAIT || state == ST_DEV_WAIT))
    else $error("divider result arrived outside a wait state");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROT && rot_cnt == ROT_LAST) |=> (state == ST_DEV && rot_cnt == '0))
    else $error("deviation walk did not end after one lap of the ring");

  a_large_latches: assert property (@(posedge clk) disable iff (rst)
    (out_load && analysed_pend && kind_next == EV_LARGE) |=> large_latched)
    else $error("large-target event not latched");

endmodule

[bench/window_deviation_anomaly_detector_tb.sv]
// Self-checking bench for window_deviation_anomaly_detector: stream driver, result monitor
// and a transaction-level predictor of window statistics, events and grouping.
// Depends on wdad_pkg and the detector RTL only.
module window_deviation_anomaly_detector_tb;
  import wdad_pkg::*;

  localparam int WINDOW_LEN  = 10;
  localparam int SAMPLE_BITS = 24;
  localparam int S_W         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_W         = ((2 * SAMPLE_BITS + 19 + 7) / 8) * 8;
  // settle time after the last result: one full analysis pass plus margin
  localparam int SETTLE      = 2 * WINDOW_LEN + 16;
  localparam int LIMIT       = 600000;

  localparam logic [SAMPLE_BITS-1:0] SMIN = 24'h800000;
  localparam logic [SAMPLE_BITS-1:0] SMAX = 24'h7FFFFF;

  // one result as the detector should report it
  typedef struct {
    logic                          analysed;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0]        dev;
    event_kind_t                   kind;
    logic                          grouped;
    logic [CNT_BITS-1:0]           count;
  } detection_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_W-1:0]           s_tdata = '0;    // [23:0] sample
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  // [23:0] window_mean, [47:24] deviation, [49:48] event_kind, [50] group_done,
  // [66:51] group_count, [71:67] zero pad
  logic [M_W-1:0]           m_tdata;
  logic                     m_tuser;         // [0] analysed
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  window_deviation_anomaly_detector #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and of the detector state.
  // ---------------------------------------------------------------------------
  logic                          sweep_on     = 1'b0;
  logic [THR_BITS-1:0]           low_thr      = 24'd30000;
  logic [THR_BITS-1:0]           high_thr     = 24'd150000;
  logic [CNT_BITS-1:0]           quiet_lim    = 16'd250;
  logic [CNT_BITS-1:0]           min_ev       = 16'd2;

  logic signed [SAMPLE_BITS-1:0] hist [WINDOW_LEN];
  int                            filled       = 0;
  logic                          small_held   = 1'b0;
  logic                          large_held   = 1'b0;
  logic [CNT_BITS-1:0]           quiet_run    = '0;
  logic [CNT_BITS-1:0]           event_tally  = '0;
  logic [CNT_BITS-1:0]           target_tally = '0;

  logic [SAMPLE_BITS-1:0]        sample_q [$];    // samples waiting for the driver
  detection_t                    detection_q [$]; // detections owed by the block
  detection_t                    predicted;
  detection_t                    want;

  int cycle_no   = 0;
  int failures   = 0;
  int n_results  = 0;
  int n_analysed = 0;
  int n_small    = 0;
  int n_large    = 0;
  int n_groups   = 0;
  int n_ignored  = 0;

  initial begin
    for (int i = 0; i < WINDOW_LEN; i++) hist[i] = '0;
  end

  function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Advance the predictor by one accepted sample; return 0 when the sample is dropped.
  function automatic bit predict_detection(input logic [SAMPLE_BITS-1:0] raw,
                                           output detection_t r);
    longint sum, mean, dsum, d, dev;
    r.analysed = 1'b0;
    r.mean     = '0;
    r.dev      = '0;
    r.kind     = EV_NONE;
    r.grouped  = 1'b0;
    r.count    = target_tally;
    if (!sweep_on) return 0;

    for (int i = 0; i < WINDOW_LEN - 1; i++) hist[i] = hist[i + 1];
    hist[WINDOW_LEN - 1] = raw;
    if (filled < WINDOW_LEN) filled++;
    // window still filling: store only
    if (filled < WINDOW_LEN) return 1;

    sum = 0;
    for (int i = 0; i < WINDOW_LEN; i++) sum += hist[i];
    mean = sum / WINDOW_LEN;          // truncates toward zero
    dsum = 0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      d = hist[i] - mean;
      dsum += (d < 0) ? -d : d;
    end
    dev = dsum / WINDOW_LEN;

    if (dev > longint'(low_thr) && dev < longint'(high_thr)) begin
      // small band: fire once, then hold until the deviation drops
      if (!small_held) begin
        event_tally = bump(event_tally);
        small_held  = 1'b1;
        quiet_run   = '0;
        r.kind      = EV_SMALL;
      end
    end else if (dev >= longint'(high_thr)) begin
      if (!large_held) begin
        event_tally = bump(event_tally);
        large_held  = 1'b1;
        quiet_run   = '0;
        r.kind      = EV_LARGE;
      end
    end else begin
      small_held = 1'b0;
      large_held = 1'b0;
      quiet_run  = bump(quiet_run);
    end

    if (quiet_run > quiet_lim && event_tally > min_ev) begin
      target_tally = bump(target_tally);
      quiet_run    = '0;
      event_tally  = '0;
      r.grouped    = 1'b1;
    end

    r.analysed = 1'b1;
    r.mean     = mean[SAMPLE_BITS-1:0];
    r.dev      = dev[SAMPLE_BITS-1:0];
    r.count    = target_tally;
    return 1;
  endfunction

  // Random stalls on both sides, with a chance of about 9 in 100; none in a long stretch
  // at the start of each period of the cycle counter, so that back-to-back transfers are seen too.
  function automatic bit pause_now();
    if ((cycle_no % 5000) < 1500) return 1'b0;
    return $urandom_range(0, 99) < 9;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued samples; predict each one at its transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (predict_detection(s_tdata[SAMPLE_BITS-1:0], predicted)) begin
          detection_q = {detection_q, predicted};
          n_analysed += predicted.analysed;
          n_small    += (predicted.kind == EV_SMALL);
          n_large    += (predicted.kind == EV_LARGE);
          n_groups   += predicted.grouped;
        end else begin
          n_ignored++;
        end
      end
      // hold tvalid and tdata until the transfer; only then pick the next one
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() != 0 && !pause_now()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest owed detection.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (detection_q.size() == 0) begin
          $error("result with nothing owed: tdata %h tuser %b", m_tdata, m_tuser);
          failures++;
        end else begin
          want = detection_q.pop_front();
          if (m_tuser !== want.analysed) begin
            $error("analysed: expected %0d, got %0d", want.analysed, m_tuser);
            failures++;
          end
          if (m_tdata[23:0] !== want.mean) begin
            $error("window_mean: expected %0d, got %0d", want.mean, $signed(m_tdata[23:0]));
            failures++;
          end
          if (m_tdata[47:24] !== want.dev) begin
            $error("deviation: expected %0d, got %0d", want.dev, m_tdata[47:24]);
            failures++;
          end
          if (m_tdata[49:48] !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, m_tdata[49:48]);
            failures++;
          end
          if (m_tdata[50] !== want.grouped) begin
            $error("group_done: expected %0d, got %0d", want.grouped, m_tdata[50]);
            failures++;
          end
          if (m_tdata[66:51] !== want.count) begin
            $error("group_count: expected %0d, got %0d", want.count, m_tdata[66:51]);
            failures++;
          end
        end
      end
      m_tready <= !pause_now();
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Append one sample to the driver's queue.
  task automatic queue_sample(input logic [SAMPLE_BITS-1:0] s);
    sample_q = {sample_q, s};
  endtask

  // Write one register at a clock edge and mirror it in the predictor.
  // Indexes beyond the register list are dropped by both.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SWEEP_ENABLE:   sweep_on  = val[0];
      CFG_LOW_THRESHOLD:  low_thr   = val[THR_BITS-1:0];
      CFG_HIGH_THRESHOLD: high_thr  = val[THR_BITS-1:0];
      CFG_QUIET_LIMIT:    quiet_lim = val[CNT_BITS-1:0];
      CFG_MIN_EVENTS:     min_ev    = val[CNT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_detection(input logic [THR_BITS-1:0] lo, input logic [THR_BITS-1:0] hi,
                               input logic [CNT_BITS-1:0] quiet, input logic [CNT_BITS-1:0] evs);
    write_reg(CFG_LOW_THRESHOLD, CFG_DATA_BITS'(lo));
    write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_BITS'(hi));
    write_reg(CFG_QUIET_LIMIT, CFG_DATA_BITS'(quiet));
    write_reg(CFG_MIN_EVENTS, CFG_DATA_BITS'(evs));
  endtask

  // Wait until every sample is taken and every result is back, then let one more
  // analysis pass run out, since a dropped sample owes no result to wait for.
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || detection_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Queue a sensor trace: quiet runs, small and large bursts around the current
  // thresholds, and short spells of full-range noise.
  task automatic queue_trace(input int n);
    int     made, run, mode;
    longint base, amp, v;
    made = 0;
    while (made < n) begin
      mode = $urandom_range(0, 9);
      run  = (mode == 0) ? $urandom_range(1, 3) : $urandom_range(3, 30);
      base = longint'($urandom_range(0, 4000000)) - 2000000;
      case (mode)
        1, 2, 3, 4: amp = longint'(low_thr);                      // deviation near low/2
        5, 6, 7:    amp = longint'(low_thr) + longint'(high_thr); // inside the small band
        default:    amp = 3 * longint'(high_thr);                 // above high
      endcase
      if (amp > 8388607) amp = 8388607;
      for (int k = 0; k < run && made < n; k++) begin
        if (mode == 0) begin
          queue_sample(SAMPLE_BITS'($urandom()));
        end else begin
          v = base + longint'($urandom_range(0, 32'(2 * amp))) - amp;
          if (v > 8388607) v = 8388607;
          if (v < -8388608) v = -8388608;
          queue_sample(v[SAMPLE_BITS-1:0]);
        end
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sweep is off after reset: these samples must vanish without a trace
    queue_sample(SMAX);
    queue_sample(SMIN);
    queue_sample('0);
    queue_sample(SAMPLE_BITS'($urandom()));
    drain();

    // fill the window with extremes, then a large event and its latched repeat
    write_reg(CFG_SWEEP_ENABLE, CFG_DATA_BITS'(1));
    queue_sample(SMIN);
    queue_sample(SMAX);
    queue_sample(SMIN);
    queue_sample(SMAX);
    queue_sample(24'd0);
    queue_sample(24'hFFFFFF);
    queue_sample(24'd1);
    queue_sample(SMIN);
    queue_sample(SMAX);
    queue_sample(SMAX);
    queue_sample(SMIN);
    drain();

    // lift high to full scale: the same spread now sits in the small band
    write_reg(CFG_HIGH_THRESHOLD, '1);
    queue_sample(SMAX);
    queue_sample(SMIN);
    drain();

    // low at full scale empties the small band: quiet sample, latches clear
    write_reg(CFG_LOW_THRESHOLD, '1);
    queue_sample('0);
    drain();

    // both thresholds at zero: every deviation is large
    write_reg(CFG_LOW_THRESHOLD, '0);
    write_reg(CFG_HIGH_THRESHOLD, '0);
    queue_sample(SMAX);
    queue_sample('0);
    drain();

    // writes past the register list are dropped
    for (int idx = CFG_MIN_EVENTS + 1; idx < (1 << CFG_IDX_BITS); idx++)
      write_reg(idx[CFG_IDX_BITS-1:0], CFG_DATA_BITS'($urandom()));

    // random traces under several threshold settings
    set_detection(24'd2000, 24'd12000, 16'd4, 16'd1);
    queue_trace(300);
    drain();

    repeat (3) begin
      low_thr = THR_BITS'($urandom_range(0, 60000));
      set_detection(low_thr, THR_BITS'(low_thr + $urandom_range(1, 5 * low_thr + 1)),
                    CNT_BITS'($urandom_range(0, 20)), CNT_BITS'($urandom_range(0, 3)));
      queue_trace(300);
      drain();
    end

    // group as eagerly as possible
    set_detection(24'd0, 24'd1, 16'd0, 16'd0);
    queue_trace(200);
    drain();

    // pause the sweep mid-trace: state must survive untouched
    write_reg(CFG_SWEEP_ENABLE, CFG_DATA_BITS'(0));
    queue_trace(30);
    drain();
    write_reg(CFG_SWEEP_ENABLE, CFG_DATA_BITS'(1));
    queue_trace(100);
    drain();

    // every register at its top value: all quiet, never grouped
    set_detection('1, '1, '1, '1);
    queue_trace(150);
    drain();

    // low above high: only large events, latched for good
    set_detection('1, 24'd0, 16'd3, 16'd0);
    queue_trace(100);
    drain();

    // back to the reset values
    set_detection(LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST, QUIET_LIMIT_RST, MIN_EVENTS_RST);
    queue_trace(400);
    drain();

    $display("checked %0d result transfers, %0d with full-window statistics",
             n_results, n_analysed);
    $display("small events %0d, large events %0d, targets grouped %0d, dropped samples %0d",
             n_small, n_large, n_groups, n_ignored);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/wdad_pkg.sv
design/wdad_cell.sv
design/wdad_cdiv.sv
design/window_deviation_anomaly_detector.sv
bench/window_deviation_anomaly_detector_tb.sv
